@@ rtl/core/tee_pkg.sv @@
// ----------------------------------------------------------------------------
// tee_pkg
// Shared types, character codes and helpers for the text escape encoder.
// ----------------------------------------------------------------------------
package tee_pkg;

	localparam int CP_W        = 21;
	localparam int MAX_RESULTS = 10;
	localparam int IDX_W       = $clog2(MAX_RESULTS);
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int EOL_MAX_DEF = 2;
	localparam int EOL_REGS    = 2;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_QUOTE_DOUBLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_HIGH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EOL_LENGTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EOL_FIRST    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EOL_SECOND   = 3'd4;

	// character codes
	localparam logic [CP_W-1:0] CH_BS     = 21'h08;
	localparam logic [CP_W-1:0] CH_TAB    = 21'h09;
	localparam logic [CP_W-1:0] CH_LF     = 21'h0A;
	localparam logic [CP_W-1:0] CH_FF     = 21'h0C;
	localparam logic [CP_W-1:0] CH_CR     = 21'h0D;
	localparam logic [CP_W-1:0] CH_SPACE  = 21'h20;
	localparam logic [CP_W-1:0] CH_DQUOTE = 21'h22;
	localparam logic [CP_W-1:0] CH_SQUOTE = 21'h27;
	localparam logic [CP_W-1:0] CH_BSL    = 21'h5C;
	localparam logic [CP_W-1:0] CH_DEL    = 21'h7F;
	localparam logic [CP_W-1:0] CH_HIGH   = 21'h80;
	localparam logic [CP_W-1:0] CH_ASTRAL = 21'h10000;
	localparam logic [CP_W-1:0] CH_ZERO   = 21'h30;
	localparam logic [CP_W-1:0] CH_UPPER_A = 21'h41;
	localparam logic [CP_W-1:0] CH_UPPER_U = 21'h55;
	localparam logic [CP_W-1:0] CH_B      = 21'h62;
	localparam logic [CP_W-1:0] CH_F      = 21'h66;
	localparam logic [CP_W-1:0] CH_N      = 21'h6E;
	localparam logic [CP_W-1:0] CH_R      = 21'h72;
	localparam logic [CP_W-1:0] CH_T      = 21'h74;
	localparam logic [CP_W-1:0] CH_U      = 21'h75;
	localparam logic [CP_W-1:0] CH_X      = 21'h78;

	typedef struct packed {
		logic            quote_double;
		logic            escape_high;
		logic [1:0]      eol_length;
		logic [CP_W-1:0] eol_first;
		logic [CP_W-1:0] eol_second;
	} cfg_t;

	// expansion of one item: count of words, the words, next CR flag
	typedef struct packed {
		logic [CNT_W-1:0]                  count;
		logic [MAX_RESULTS-1:0][CP_W-1:0] cps;
		logic                              pend_next;
	} plan_t;

	function automatic logic [CP_W-1:0] hex_digit(input logic [3:0] v);
		logic [CP_W-1:0] d;
		d = {{(CP_W-4){1'b0}}, v};
		if (v < 4'd10) begin
			return CH_ZERO + d;
		end
		return CH_UPPER_A + d - 21'd10;
	endfunction

endpackage

@@ rtl/core/tee_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// tee_cfg_regs
// Configuration register file written through a write-enable port.
// ----------------------------------------------------------------------------
module tee_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [tee_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [tee_pkg::CP_W-1:0]       wr_data,
	output tee_pkg::cfg_t                  cfg
);
	import tee_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.quote_double <= 1'b1;
			cfg_q.escape_high  <= 1'b1;
			cfg_q.eol_length   <= 2'd0;
			cfg_q.eol_first    <= CH_CR;
			cfg_q.eol_second   <= CH_LF;
		end else if (wr_en) begin
			case (wr_index)
				REG_QUOTE_DOUBLE: cfg_q.quote_double <= wr_data[0];
				REG_ESCAPE_HIGH:  cfg_q.escape_high  <= wr_data[0];
				REG_EOL_LENGTH:   cfg_q.eol_length   <= wr_data[1:0];
				REG_EOL_FIRST:    cfg_q.eol_first    <= wr_data;
				REG_EOL_SECOND:   cfg_q.eol_second   <= wr_data;
				default: begin
					// drop writes beyond the register list
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/core/tee_decode.sv @@
// ----------------------------------------------------------------------------
// tee_decode
// Builds the escaped expansion of one registered item.
// ----------------------------------------------------------------------------
module tee_decode #(
	parameter int EOL_MAX = tee_pkg::EOL_MAX_DEF
) (
	input  logic [tee_pkg::CP_W-1:0] code_point,
	input  logic                     mode,
	input  logic                     pending_cr,
	input  tee_pkg::cfg_t            cfg,
	output tee_pkg::plan_t           plan
);
	import tee_pkg::*;

	localparam int EOL_CAP = (EOL_MAX < EOL_REGS) ? EOL_MAX : EOL_REGS;

	logic [1:0]       eol_n;
	logic [CNT_W-1:0] eol_cnt;
	logic [31:0]      wide;
	logic             is_ctrl;
	logic             is_plain;

	assign eol_n   = (cfg.eol_length > 2'(EOL_CAP)) ? 2'(EOL_CAP) : cfg.eol_length;
	assign eol_cnt = CNT_W'(eol_n);
	assign wide    = {{(32-CP_W){1'b0}}, code_point};
	assign is_ctrl = (code_point < CH_SPACE) || (code_point == CH_DEL);
	assign is_plain = (code_point < CH_HIGH) || !cfg.escape_high;

	always_comb begin
		plan = '0;
		if (mode) begin
			// end of stream: flush a held CR
			if (pending_cr) begin
				plan.cps[0] = CH_BSL;
				plan.cps[1] = CH_R;
				plan.cps[2] = cfg.eol_first;
				plan.cps[3] = cfg.eol_second;
				plan.count  = CNT_W'(2) + eol_cnt;
			end
		end else if (is_ctrl) begin
			case (code_point)
				CH_TAB: begin
					plan.cps[0] = CH_BSL;
					plan.cps[1] = CH_T;
					plan.count  = CNT_W'(2);
				end
				CH_BS: begin
					plan.cps[0] = CH_BSL;
					plan.cps[1] = CH_B;
					plan.count  = CNT_W'(2);
				end
				CH_FF: begin
					plan.cps[0] = CH_BSL;
					plan.cps[1] = CH_F;
					plan.count  = CNT_W'(2);
				end
				CH_LF: begin
					if (pending_cr) begin
						plan.cps[0] = CH_BSL;
						plan.cps[1] = CH_R;
						plan.cps[2] = CH_BSL;
						plan.cps[3] = CH_N;
						plan.cps[4] = cfg.eol_first;
						plan.cps[5] = cfg.eol_second;
						plan.count  = CNT_W'(4) + eol_cnt;
					end else begin
						plan.cps[0] = CH_BSL;
						plan.cps[1] = CH_N;
						plan.cps[2] = cfg.eol_first;
						plan.cps[3] = cfg.eol_second;
						plan.count  = CNT_W'(2) + eol_cnt;
					end
				end
				CH_CR: begin
					// hold this CR; emit the one already held
					if (pending_cr) begin
						plan.cps[0] = CH_BSL;
						plan.cps[1] = CH_R;
						plan.cps[2] = cfg.eol_first;
						plan.cps[3] = cfg.eol_second;
						plan.count  = CNT_W'(2) + eol_cnt;
					end
					plan.pend_next = 1'b1;
				end
				default: begin
					plan.cps[0] = CH_BSL;
					plan.cps[1] = CH_X;
					plan.cps[2] = hex_digit(wide[7:4]);
					plan.cps[3] = hex_digit(wide[3:0]);
					plan.count  = CNT_W'(4);
				end
			endcase
		end else if (is_plain) begin
			if ((cfg.quote_double && code_point == CH_DQUOTE) ||
			    (!cfg.quote_double && code_point == CH_SQUOTE) ||
			    (code_point == CH_BSL)) begin
				plan.cps[0] = CH_BSL;
				plan.cps[1] = code_point;
				plan.count  = CNT_W'(2);
			end else begin
				plan.cps[0] = code_point;
				plan.count  = CNT_W'(1);
			end
		end else if (code_point < CH_ASTRAL) begin
			plan.cps[0] = CH_BSL;
			plan.cps[1] = CH_U;
			for (int i = 0; i < 4; i++) begin
				plan.cps[2+i] = hex_digit(wide[(15-4*i) -: 4]);
			end
			plan.count = CNT_W'(6);
		end else begin
			plan.cps[0] = CH_BSL;
			plan.cps[1] = CH_UPPER_U;
			for (int i = 0; i < 8; i++) begin
				plan.cps[2+i] = hex_digit(wide[(31-4*i) -: 4]);
			end
			plan.count = CNT_W'(10);
		end
	end

endmodule

@@ rtl/core/text_escape_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// text_escape_encoder_unit
// Escapes a stream of code points into C-style text, one word per result.
// ----------------------------------------------------------------------------
// Flow: an accepted item is registered in the item stage, then each word
//   of its expansion (1..10 words) in the single result register, one word
//   per cycle while res_stall is low; an item with no words (a held CR, or
//   end of stream with none held) leaves the item stage, loading no result.
// Reset: arst_n clears the item and result stages, the held-CR flag and the
//   configuration registers to their defaults.
module text_escape_encoder_unit #(
	parameter int EOL_MAX = tee_pkg::EOL_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// item channel
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic [tee_pkg::CP_W-1:0]       code_point,
	input  logic                           mode,
	// result channel
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic [tee_pkg::CP_W-1:0]       out_code_point,
	output logic                           last,
	// configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tee_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tee_pkg::CP_W-1:0]       cfg_data
);
	import tee_pkg::*;

	cfg_t  cfg;
	plan_t plan;

	// item stage
	logic            valid_s1;
	logic [CP_W-1:0] code_point_s1;
	logic            mode_s1;

	// word index within the current expansion, held CR flag
	logic [IDX_W-1:0] idx_q;
	logic             pending_cr_q;

	// result stage
	logic            res_valid_q;
	logic [CP_W-1:0] res_cp_q;
	logic            res_last_q;

	logic item_accept;
	logic out_free;
	logic load_out;
	logic word_last;
	logic consume;

	// Issue writes only while idle (block does not check); always ready.
	assign cfg_ready = 1'b1;

	tee_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	tee_decode #(
		.EOL_MAX (EOL_MAX)
	) u_decode (
		.code_point (code_point_s1),
		.mode       (mode_s1),
		.pending_cr (pending_cr_q),
		.cfg        (cfg),
		.plan       (plan)
	);

	// The result register takes a word when empty or when its word leaves.
	assign out_free  = !res_valid_q || !res_stall;
	assign load_out  = valid_s1 && (plan.count != '0) && out_free;
	assign word_last = (CNT_W'(idx_q) == (plan.count - CNT_W'(1)));

	// The item leaves the stage with its final word, or at once if it has none.
	assign consume = valid_s1 && ((plan.count == '0) || (load_out && word_last));

	// Take a new item when the stage is empty or empties in this same cycle.
	assign item_stall  = valid_s1 && !consume;
	assign item_accept = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_accept) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_accept) begin
			code_point_s1 <= code_point;
			mode_s1       <= mode;
		end
	end

	// Advance through the expansion one word per loaded result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			pending_cr_q <= 1'b0;
		end else begin
			if (consume) begin
				idx_q        <= '0;
				pending_cr_q <= plan.pend_next;
			end else if (load_out) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_cp_q   <= plan.cps[idx_q];
			res_last_q <= word_last;
		end
	end

	assign res_valid      = res_valid_q;
	assign out_code_point = res_cp_q;
	assign last           = res_last_q;

	// The word index stays inside the current expansion.
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (plan.count != '0) |-> (CNT_W'(idx_q) < plan.count))
		else $error("word index beyond expansion length");

	// With no item in the stage the index rests at zero.
	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> (idx_q == '0))
		else $error("word index not cleared between items");

	// The CR flag is only set by a consumed CR item.
	a_cr_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pending_cr_q) |-> $past(consume && !mode_s1 && (code_point_s1 == CH_CR)))
		else $error("held CR set without a CR item");

	// A stalled result word is never overwritten.
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_stall |-> !load_out)
		else $error("result register loaded while stalled");

endmodule
